// File: rtl/core/aapr_pkg.sv
// Shared types, widths and constants of the axis-angle point rotator.
// No dependencies; every other file of the block imports this package.
package aapr_pkg;

    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;
    localparam int COEF_N         = 9;
    localparam int RND_SH         = 30 - COEF_FRAC_BITS;

    localparam int XW = 32;
    localparam int PW = COEF_W + XW;
    localparam int SW = PW + 2;

    localparam int QW = 35;

    localparam int DIV_NUM_W = 63;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam int CFG_IDX_W = 2;

    typedef logic signed [QW-1:0]     q_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    localparam q_t    Q30_ONE     = 35'sd1073741824;
    localparam q_t    Q30_PI      = 35'sd3373259426;
    localparam q_t    Q30_HALF_PI = 35'sd1686629713;
    localparam coef_t COEF_ONE    = coef_t'(longint'(1) << COEF_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_X = 2'd0,
        REG_AXIS_Y = 2'd1,
        REG_AXIS_Z = 2'd2,
        REG_ANGLE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic        write;
        cfg_reg_t    index;
        logic [31:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic signed [XW-1:0] in_x;
        logic signed [XW-1:0] in_y;
        logic signed [XW-1:0] in_z;
        logic                 last_point;
    } in_beat_t;

    typedef struct packed {
        logic signed [XW-1:0] rotated_x;
        logic signed [XW-1:0] rotated_y;
        logic signed [XW-1:0] rotated_z;
        logic                 last_out;
    } out_beat_t;

    function automatic logic [31:0] mag32(q_t v);
        q_t a;
        a = v[QW-1] ? -v : v;
        return a[31:0];
    endfunction

endpackage

// File: rtl/core/aapr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on aapr_pkg; used by the coefficient builder.
module aapr_div import aapr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [31:0]          quot
);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] nq_reg, nq_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   sh;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    always_comb
    begin
        sh       = {rem_reg, nq_reg[DIV_NUM_W-1]};
        diff     = sh - {1'b0, den_reg};
        ge       = sh >= {1'b0, den_reg};
        rem_next = ge ? diff[DIV_DEN_W-1:0] : sh[DIV_DEN_W-1:0];
        nq_next  = {nq_reg[DIV_NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            nq_reg  <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    assign done = done_reg;
    assign quot = nq_reg[31:0];

endmodule

// File: rtl/core/aapr_coef.sv
// Configuration registers and the sequencer that builds the nine rotation
// coefficients. Depends on aapr_pkg and aapr_div.
module aapr_coef import aapr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_wr_t cfg,
    output logic    coef_ready,
    output coef_t   coef [COEF_N]
);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_LOAD = 11'b000_0000_0010,
        ST_NORM = 11'b000_0000_0100,
        ST_SQ   = 11'b000_0000_1000,
        ST_SQRT = 11'b000_0001_0000,
        ST_UDIV = 11'b000_0010_0000,
        ST_TRIG = 11'b000_0100_0000,
        ST_TSUB = 11'b000_1000_0000,
        ST_PROD = 11'b001_0000_0000,
        ST_RAW  = 11'b010_0000_0000,
        ST_RND  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic signed [31:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [15:0] ang_reg, ang_next;
    logic [31:0] mg_reg [3];
    logic [31:0] mg_next [3];
    logic        ng_reg [3];
    logic        ng_next [3];
    logic [63:0] sum_reg, sum_next, res_reg, res_next, bit_reg, bit_next;
    logic [31:0] r_reg, r_next;
    q_t          u_reg [3];
    q_t          u_next [3];
    q_t          x_reg, x_next, c_reg, c_next, s_reg, s_next, t_reg, t_next;
    logic [31:0] term_mg_reg, term_mg_next;
    logic        term_ng_reg, term_ng_next;
    logic        flip_reg, flip_next;
    q_t          p_reg [COEF_N];
    q_t          p_next [COEF_N];
    coef_t       coef_reg [COEF_N];
    coef_t       coef_next [COEF_N];
    logic [31:0] ma_reg, ma_next, mb_reg, mb_next;
    logic        mneg_reg, mneg_next;
    logic [63:0] prod_reg;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [31:0]          div_quot;

    logic        mul_issue;
    q_t          opa, opb;
    logic [33:0] mq_mag;
    q_t          mq;
    q_t          axis_q [3];
    q_t          xa;
    q_t          qv;
    logic [63:0] rb;
    logic [3:0]  pi_sel;
    logic [3:0]  dst;

    function automatic q_t clamp_one(q_t v);
        if (v > Q30_ONE)
            return Q30_ONE;
        if (v < -Q30_ONE)
            return -Q30_ONE;
        return v;
    endfunction

    function automatic coef_t to_coef(q_t v);
        q_t         a;
        logic [QW-1:0] m;
        logic [QW-1:0] r;
        logic [QW-1:0] lim;
        a   = v[QW-1] ? -v : v;
        m   = a;
        lim = QW'(1) << COEF_FRAC_BITS;
        r   = (m + (QW'(1) << (RND_SH - 1))) >> RND_SH;
        if (r > lim)
            r = lim;
        return v[QW-1] ? -coef_t'(r) : coef_t'(r);
    endfunction

    aapr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign mq_mag = 34'((prod_reg + (64'd1 << 29)) >> 30);
    assign mq     = mneg_reg ? -q_t'(mq_mag) : q_t'(mq_mag);

    always_comb
    begin
        axis_q[0] = q_t'(ax_reg);
        axis_q[1] = q_t'(ay_reg);
        axis_q[2] = q_t'(az_reg);
        xa        = q_t'(ang_reg) <<< 17;
        rb        = res_reg + bit_reg;
        pi_sel    = 4'(idx_reg - 5'd9);
        dst       = (idx_reg < 5'd9) ? idx_reg[3:0] : pi_sel;
        qv        = '0;

        state_next   = state_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        az_next      = az_reg;
        ang_next     = ang_reg;
        sum_next     = sum_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        r_next       = r_reg;
        x_next       = x_reg;
        c_next       = c_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        term_mg_next = term_mg_reg;
        term_ng_next = term_ng_reg;
        flip_next    = flip_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        mneg_next    = mneg_reg;
        for (int i = 0; i < 3; i++)
        begin
            mg_next[i] = mg_reg[i];
            ng_next[i] = ng_reg[i];
            u_next[i]  = u_reg[i];
        end
        for (int i = 0; i < COEF_N; i++)
        begin
            p_next[i]    = p_reg[i];
            coef_next[i] = coef_reg[i];
        end
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        mul_issue = 1'b0;
        opa       = '0;
        opb       = '0;

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mg_next[i] = mag32(axis_q[i]);
                    ng_next[i] = axis_q[i][QW-1];
                end
                if (xa > Q30_HALF_PI)
                begin
                    x_next    = xa - Q30_PI;
                    flip_next = 1'b1;
                end
                else if (xa < -Q30_HALF_PI)
                begin
                    x_next    = xa + Q30_PI;
                    flip_next = 1'b1;
                end
                else
                begin
                    x_next    = xa;
                    flip_next = 1'b0;
                end
                c_next       = Q30_ONE;
                s_next       = x_next;
                term_mg_next = mag32(x_next);
                term_ng_next = x_next[QW-1];
                sum_next     = '0;
                idx_next     = '0;
                phase_next   = '0;
                if ((ax_reg == '0) && (ay_reg == '0) && (az_reg == '0))
                begin
                    for (int i = 0; i < COEF_N; i++)
                        coef_next[i] = (i % 4 == 0) ? COEF_ONE : '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if ((mg_reg[0][31:30] | mg_reg[1][31:30] | mg_reg[2][31:30]) == 2'b00)
                begin
                    for (int i = 0; i < 3; i++)
                        mg_next[i] = mg_reg[i] << 1;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                opa = q_t'(mg_reg[idx_reg[1:0]]);
                opb = opa;
                if (phase_reg == 2'd0)
                begin
                    mul_issue  = 1'b1;
                    phase_next = 2'd1;
                end
                else if (phase_reg == 2'd1)
                begin
                    phase_next = 2'd2;
                end
                else
                begin
                    sum_next   = sum_reg + prod_reg;
                    phase_next = 2'd0;
                    if (idx_reg == 5'd2)
                    begin
                        idx_next   = '0;
                        res_next   = '0;
                        bit_next   = 64'd1 << 62;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_SQRT:
            begin
                if (sum_reg >= rb)
                begin
                    sum_next = sum_reg - rb;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 5'd31)
                begin
                    r_next     = res_next[31:0];
                    idx_next   = '0;
                    phase_next = '0;
                    state_next = ST_UDIV;
                end
            end
            ST_UDIV:
            begin
                if (phase_reg == 2'd0)
                begin
                    div_start  = 1'b1;
                    div_num    = DIV_NUM_W'({mg_reg[idx_reg[1:0]], 30'd0})
                               + DIV_NUM_W'(r_reg >> 1);
                    div_den    = r_reg;
                    phase_next = 2'd1;
                end
                else if (div_done)
                begin
                    qv = ng_reg[idx_reg[1:0]] ? -q_t'(div_quot) : q_t'(div_quot);
                    u_next[idx_reg[1:0]] = clamp_one(qv);
                    phase_next = 2'd0;
                    if (idx_reg == 5'd2)
                    begin
                        idx_next   = 5'd2;
                        state_next = ST_TRIG;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_TRIG:
            begin
                opa = term_ng_reg ? -q_t'(term_mg_reg) : q_t'(term_mg_reg);
                opb = x_reg;
                if (phase_reg == 2'd0)
                begin
                    mul_issue  = 1'b1;
                    phase_next = 2'd1;
                end
                else if (phase_reg == 2'd1)
                begin
                    phase_next = 2'd2;
                end
                else if (phase_reg == 2'd2)
                begin
                    div_start  = 1'b1;
                    div_num    = DIV_NUM_W'(mq_mag);
                    div_den    = DIV_DEN_W'(idx_reg);
                    phase_next = 2'd3;
                end
                else if (div_done)
                begin
                    qv           = mneg_reg ? -q_t'(div_quot) : q_t'(div_quot);
                    term_mg_next = div_quot;
                    term_ng_next = mneg_reg;
                    case (idx_reg[1:0])
                        2'd0:    c_next = c_reg + qv;
                        2'd1:    s_next = s_reg + qv;
                        2'd2:    c_next = c_reg - qv;
                        default: s_next = s_reg - qv;
                    endcase
                    phase_next = 2'd0;
                    if (idx_reg == 5'd21)
                        state_next = ST_TSUB;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_TSUB:
            begin
                c_next     = flip_reg ? -clamp_one(c_reg) : clamp_one(c_reg);
                s_next     = flip_reg ? -clamp_one(s_reg) : clamp_one(s_reg);
                idx_next   = '0;
                phase_next = '0;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                t_next = Q30_ONE - c_reg;
                case (idx_reg)
                    5'd0:    begin opa = u_reg[0]; opb = u_reg[0]; end
                    5'd1:    begin opa = u_reg[1]; opb = u_reg[1]; end
                    5'd2:    begin opa = u_reg[2]; opb = u_reg[2]; end
                    5'd3:    begin opa = u_reg[0]; opb = u_reg[1]; end
                    5'd4:    begin opa = u_reg[0]; opb = u_reg[2]; end
                    5'd5:    begin opa = u_reg[1]; opb = u_reg[2]; end
                    5'd6:    begin opa = u_reg[0]; opb = s_reg;    end
                    5'd7:    begin opa = u_reg[1]; opb = s_reg;    end
                    5'd8:    begin opa = u_reg[2]; opb = s_reg;    end
                    default: begin opa = t_reg;    opb = p_reg[pi_sel]; end
                endcase
                if (phase_reg == 2'd0)
                begin
                    mul_issue  = 1'b1;
                    phase_next = 2'd1;
                end
                else if (phase_reg == 2'd1)
                begin
                    phase_next = 2'd2;
                end
                else
                begin
                    p_next[dst] = mq;
                    phase_next  = 2'd0;
                    if (idx_reg == 5'd14)
                        state_next = ST_RAW;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_RAW:
            begin
                p_next[0]  = c_reg + p_reg[0];
                p_next[1]  = p_reg[3] - p_reg[8];
                p_next[2]  = p_reg[4] + p_reg[7];
                p_next[3]  = p_reg[3] + p_reg[8];
                p_next[4]  = c_reg + p_reg[1];
                p_next[5]  = p_reg[5] - p_reg[6];
                p_next[6]  = p_reg[4] - p_reg[7];
                p_next[7]  = p_reg[5] + p_reg[6];
                p_next[8]  = c_reg + p_reg[2];
                state_next = ST_RND;
            end
            ST_RND:
            begin
                for (int i = 0; i < COEF_N; i++)
                    coef_next[i] = to_coef(p_reg[i]);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (mul_issue)
        begin
            ma_next   = mag32(opa);
            mb_next   = mag32(opb);
            mneg_next = opa[QW-1] ^ opb[QW-1];
        end

        if (cfg.write)
        begin
            case (cfg.index)
                REG_AXIS_X: ax_next  = cfg.data;
                REG_AXIS_Y: ay_next  = cfg.data;
                REG_AXIS_Z: az_next  = cfg.data;
                REG_ANGLE:  ang_next = cfg.data[15:0];
                default:    ang_next = ang_reg;
            endcase
            state_next = ST_LOAD;
            phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            phase_reg <= '0;
            idx_reg   <= '0;
            ax_reg    <= '0;
            ay_reg    <= '0;
            az_reg    <= 32'sd65536;
            ang_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            az_reg    <= az_next;
            ang_reg   <= ang_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        res_reg     <= res_next;
        bit_reg     <= bit_next;
        r_reg       <= r_next;
        x_reg       <= x_next;
        c_reg       <= c_next;
        s_reg       <= s_next;
        t_reg       <= t_next;
        term_mg_reg <= term_mg_next;
        term_ng_reg <= term_ng_next;
        flip_reg    <= flip_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        mneg_reg    <= mneg_next;
        prod_reg    <= ma_reg * mb_reg;
        for (int i = 0; i < 3; i++)
        begin
            mg_reg[i] <= mg_next[i];
            ng_reg[i] <= ng_next[i];
            u_reg[i]  <= u_next[i];
        end
        for (int i = 0; i < COEF_N; i++)
        begin
            p_reg[i]    <= p_next[i];
            coef_reg[i] <= coef_next[i];
        end
    end

    assign coef_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        for (int i = 0; i < COEF_N; i++)
            coef[i] = coef_reg[i];
    end

endmodule

// File: rtl/core/aapr_xform.sv
// Four-stage matrix-vector pipeline: products, row sums, rounding, saturation.
// Depends on aapr_pkg; coefficients come from aapr_coef.
module aapr_xform import aapr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      coef_ready,
    input  coef_t     coef [COEF_N],
    input  logic      src_valid,
    output logic      src_stall,
    input  in_beat_t  src_beat,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_beat_t dst_beat
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    logic signed [PW-1:0] m_reg [COEF_N];
    logic signed [PW-1:0] m_next [COEF_N];
    logic                 l1_reg, l2_reg, l3_reg;
    logic signed [SW-1:0] s_reg [3];
    logic [SW-1:0]        r_reg [3];
    logic [SW-1:0]        r_next [3];
    logic                 n_reg [3];
    logic [XW-1:0]        o_next [3];
    out_beat_t            dst_beat_reg;
    logic signed [XW-1:0] pt [3];
    logic [SW-1:0]        mag [3];

    assign adv4      = !v4_reg || !dst_stall;
    assign adv3      = !v3_reg || adv4;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign src_stall = !coef_ready || !adv1;

    always_comb
    begin
        pt[0] = src_beat.in_x;
        pt[1] = src_beat.in_y;
        pt[2] = src_beat.in_z;
        for (int i = 0; i < COEF_N; i++)
            m_next[i] = coef[i] * pt[i % 3];
        for (int k = 0; k < 3; k++)
        begin
            mag[k]    = s_reg[k][SW-1] ? SW'(-s_reg[k]) : SW'(s_reg[k]);
            r_next[k] = (mag[k] + (SW'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
            if (!n_reg[k] && (r_reg[k] > SW'(64'h7FFF_FFFF)))
                o_next[k] = 32'h7FFF_FFFF;
            else if (n_reg[k] && (r_reg[k] > SW'(64'h8000_0000)))
                o_next[k] = 32'h8000_0000;
            else if (n_reg[k])
                o_next[k] = 32'd0 - r_reg[k][XW-1:0];
            else
                o_next[k] = r_reg[k][XW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= src_valid && coef_ready;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            for (int i = 0; i < COEF_N; i++)
                m_reg[i] <= m_next[i];
            l1_reg <= src_beat.last_point;
        end
        if (adv2)
        begin
            for (int k = 0; k < 3; k++)
                s_reg[k] <= SW'(m_reg[3*k]) + SW'(m_reg[3*k+1]) + SW'(m_reg[3*k+2]);
            l2_reg <= l1_reg;
        end
        if (adv3)
        begin
            for (int k = 0; k < 3; k++)
            begin
                r_reg[k] <= r_next[k];
                n_reg[k] <= s_reg[k][SW-1];
            end
            l3_reg <= l2_reg;
        end
        if (adv4)
        begin
            dst_beat_reg.rotated_x <= o_next[0];
            dst_beat_reg.rotated_y <= o_next[1];
            dst_beat_reg.rotated_z <= o_next[2];
            dst_beat_reg.last_out  <= l3_reg;
        end
    end

    assign dst_valid = v4_reg;
    assign dst_beat  = dst_beat_reg;

endmodule

// File: rtl/core/axis_angle_point_rotator_unit.sv
// Top level of the axis-angle point rotator: config port, coefficient
// builder and point pipeline. Depends on aapr_pkg, aapr_coef, aapr_xform.
//
//   channel   direction  handshake            payload
//   src       in         src_valid/src_stall  in_beat_t  (x, y, z, last_point)
//   dst       out        dst_valid/dst_stall  out_beat_t (x, y, z, last_out)
//   cfg       in         cfg_write            cfg_index, cfg_data
//
// One beat per cycle when nothing stalls; each stage holds on stall.
// After reset and after every register write the coefficients are rebuilt,
// paced by the shared bit-serial divider (Taylor terms and axis
// normalization); src_stall stays high until the build is done.
module axis_angle_point_rotator_unit import aapr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  in_beat_t             src_beat,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output out_beat_t            dst_beat,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_wr_t cfg;
    logic    coef_ready;
    coef_t   coef [COEF_N];

    always_comb
    begin
        cfg.write = cfg_write;
        cfg.index = cfg_reg_t'(cfg_index);
        cfg.data  = cfg_data;
    end

    aapr_coef u_coef (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .coef_ready (coef_ready),
        .coef       (coef)
    );

    aapr_xform u_xform (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_ready (coef_ready),
        .coef       (coef),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_beat   (src_beat),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_beat   (dst_beat)
    );

endmodule
